FILE: src/rigid_point_transform_unit_defines.svh
// Assertion macros for the rigid point transform unit
`ifndef RIGID_POINT_TRANSFORM_UNIT_DEFINES_SVH
`define RIGID_POINT_TRANSFORM_UNIT_DEFINES_SVH

// implication checked on every clock, off while in reset
`define RPTU_ASSERT_IMP(lbl, clk, rst_n, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("rptu assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define RPTU_ASSERT_NEXT(lbl, clk, rst_n, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("rptu assertion failed");

`endif

FILE: src/rptu_pkg.sv
// Types and constants of the rigid point transform unit
package rptu_pkg;

    localparam int CoordW = 32;
    localparam int QuatW  = 18;
    localparam int MatW   = 32;
    localparam int FracM  = 30;
    localparam int IdxW   = 3;
    localparam int CfgW   = 32;
    localparam int ProdW  = 2 * QuatW;
    localparam int SumW   = ProdW + 2;
    localparam int DivW   = SumW + 1;
    localparam int QuoW   = FracM + 1;
    localparam int CntW   = 5;
    localparam int KW     = 4;

    typedef enum logic [IdxW-1:0] {
        REG_ROT_X   = 3'd0,
        REG_ROT_Y   = 3'd1,
        REG_ROT_Z   = 3'd2,
        REG_ROT_W   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_PROD,
        MS_SUM,
        MS_LOAD,
        MS_DIV,
        MS_ROUND
    } t_mstate;

    typedef struct packed {
        logic signed [QuatW-1:0] x;
        logic signed [QuatW-1:0] y;
        logic signed [QuatW-1:0] z;
        logic signed [QuatW-1:0] w;
    } t_quat;

    typedef struct packed {
        logic busy;
        logic bad;
    } t_mat_stat;

    typedef struct packed {
        logic signed [CoordW-1:0] pt_x;
        logic signed [CoordW-1:0] pt_y;
        logic signed [CoordW-1:0] pt_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [CoordW-1:0] out_x;
        logic signed [CoordW-1:0] out_y;
        logic signed [CoordW-1:0] out_z;
        logic                     saturated;
        logic                     bad_rotation;
    } t_out_beat;

endpackage

FILE: src/rigid_point_transform_unit.sv
// Rigid point transform unit: quaternion rotation plus translation, saturated
// Beats pass r_p1, r_prod, r_acc, r_out; one point per cycle when not stalled.
// After a rotation register write the matrix is rebuilt by a bit-serial divider
// shared over nine entries, and input stalls while it runs.
// Synchronous active-low reset gives the identity rotation and zero translation
// at once; the pipeline empties on reset.
module rigid_point_transform_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rptu_pkg::t_in_beat            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rptu_pkg::t_out_beat           o_out_data,
    input  logic                          i_cfg_we,
    input  logic [rptu_pkg::IdxW-1:0]     i_cfg_idx,
    input  logic [rptu_pkg::CfgW-1:0]     i_cfg_data
);

    `include "rigid_point_transform_unit_defines.svh"

    localparam int PW = rptu_pkg::MatW + rptu_pkg::CoordW;
    localparam int AW = PW + 2;
    localparam int VW = AW - rptu_pkg::FracM;

    rptu_pkg::t_quat           r_quat;
    logic signed [rptu_pkg::CoordW-1:0] r_shift [3];
    logic                      r_rot_wr;

    logic signed [rptu_pkg::MatW-1:0] m [9];
    rptu_pkg::t_mat_stat       mstat;

    logic                      en;
    logic                      r_v1, r_v2, r_v3, r_v4;
    rptu_pkg::t_in_beat        r_p1;
    logic signed [PW-1:0]      r_prod [9];
    logic signed [AW-1:0]      r_acc [3];
    rptu_pkg::t_out_beat       r_out;

    logic signed [rptu_pkg::CoordW-1:0] pv [3];
    logic signed [AW-1:0]      rnd [3];
    logic signed [VW-1:0]      vv [3];
    logic signed [rptu_pkg::CoordW-1:0] res [3];
    logic [2:0]                clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat   <= '{x: '0, y: '0, z: '0, w: rptu_pkg::QuatW'(65536)};
            r_shift  <= '{default: '0};
            r_rot_wr <= 1'b0;
        end else begin
            r_rot_wr <= 1'b0;
            if (i_cfg_we) begin
                case (rptu_pkg::t_reg_idx'(i_cfg_idx))
                    rptu_pkg::REG_ROT_X: begin
                        r_quat.x <= i_cfg_data[rptu_pkg::QuatW-1:0];
                        r_rot_wr <= 1'b1;
                    end
                    rptu_pkg::REG_ROT_Y: begin
                        r_quat.y <= i_cfg_data[rptu_pkg::QuatW-1:0];
                        r_rot_wr <= 1'b1;
                    end
                    rptu_pkg::REG_ROT_Z: begin
                        r_quat.z <= i_cfg_data[rptu_pkg::QuatW-1:0];
                        r_rot_wr <= 1'b1;
                    end
                    rptu_pkg::REG_ROT_W: begin
                        r_quat.w <= i_cfg_data[rptu_pkg::QuatW-1:0];
                        r_rot_wr <= 1'b1;
                    end
                    rptu_pkg::REG_SHIFT_X: r_shift[0] <= i_cfg_data[rptu_pkg::CoordW-1:0];
                    rptu_pkg::REG_SHIFT_Y: r_shift[1] <= i_cfg_data[rptu_pkg::CoordW-1:0];
                    rptu_pkg::REG_SHIFT_Z: r_shift[2] <= i_cfg_data[rptu_pkg::CoordW-1:0];
                    default: ;
                endcase
            end
        end
    end

    rptu_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_rot_wr),
        .i_quat  (r_quat),
        .o_m     (m),
        .o_stat  (mstat)
    );

    assign en         = !(r_v4 && i_out_stall);
    assign o_in_stall = !en || mstat.busy || r_rot_wr || i_cfg_we;

    assign pv[0] = r_p1.pt_x;
    assign pv[1] = r_p1.pt_y;
    assign pv[2] = r_p1.pt_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i]  = r_acc[i] + AW'(1 << (rptu_pkg::FracM - 1));
            vv[i]   = VW'(rnd[i] >>> rptu_pkg::FracM);
            clip[i] = 1'b0;
            res[i]  = vv[i][rptu_pkg::CoordW-1:0];
            if (vv[i] > $signed(VW'({1'b0, {(rptu_pkg::CoordW-1){1'b1}}}))) begin
                clip[i] = 1'b1;
                res[i]  = {1'b0, {(rptu_pkg::CoordW-1){1'b1}}};
            end else if (vv[i] < -$signed(VW'({1'b1, {(rptu_pkg::CoordW-1){1'b0}}}))) begin
                clip[i] = 1'b1;
                res[i]  = {1'b1, {(rptu_pkg::CoordW-1){1'b0}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid && !o_in_stall;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1 <= i_in_data;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i*3+j] <= m[i*3+j] * pv[j];
                end
                r_acc[i] <= AW'(r_prod[i*3]) + AW'(r_prod[i*3+1]) + AW'(r_prod[i*3+2])
                          + (AW'(r_shift[i]) <<< rptu_pkg::FracM);
            end
            if (mstat.bad) begin
                r_out.out_x        <= r_shift[0];
                r_out.out_y        <= r_shift[1];
                r_out.out_z        <= r_shift[2];
                r_out.saturated    <= 1'b0;
                r_out.bad_rotation <= 1'b1;
            end else begin
                r_out.out_x        <= res[0];
                r_out.out_y        <= res[1];
                r_out.out_z        <= res[2];
                r_out.saturated    <= |clip;
                r_out.bad_rotation <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_data  = r_out;

    `RPTU_ASSERT_IMP(a_no_entry_busy, i_clk, i_rst_n, mstat.busy || r_rot_wr, o_in_stall)
    `RPTU_ASSERT_IMP(a_bad_no_sat, i_clk, i_rst_n, o_out_valid && o_out_data.bad_rotation, !o_out_data.saturated)
    `RPTU_ASSERT_NEXT(a_held_beat, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

endmodule

FILE: src/rptu_matrix.sv
// Rotation matrix builder: products, sums and a shared bit-serial divider
module rptu_matrix (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  rptu_pkg::t_quat                        i_quat,
    output logic signed [rptu_pkg::MatW-1:0]       o_m [9],
    output rptu_pkg::t_mat_stat                    o_stat
);

    rptu_pkg::t_mstate r_state, n_state;

    logic signed [rptu_pkg::ProdW-1:0] r_pp [10];
    logic signed [rptu_pkg::SumW-1:0]  r_e  [9];
    logic signed [rptu_pkg::SumW-1:0]  r_n;
    logic        [rptu_pkg::DivW-1:0]  r_rem;
    logic        [rptu_pkg::QuoW-1:0]  r_quo;
    logic        [rptu_pkg::CntW-1:0]  r_cnt;
    logic        [rptu_pkg::KW-1:0]    r_k;
    logic signed [rptu_pkg::MatW-1:0]  r_m [9];
    logic                              r_bad;

    logic        [rptu_pkg::DivW-1:0]  rr, rem_nx, dd;
    logic                              ge;
    logic signed [rptu_pkg::SumW-1:0]  ek, emag;
    logic        [rptu_pkg::QuoW-1:0]  qr;

    function automatic logic signed [rptu_pkg::SumW-1:0] sx(
        input logic signed [rptu_pkg::ProdW-1:0] a);
        sx = rptu_pkg::SumW'(a);
    endfunction

    always_comb begin
        dd     = rptu_pkg::DivW'(r_n[rptu_pkg::SumW-2:0]);
        rr     = (r_cnt == '0) ? r_rem : {r_rem[rptu_pkg::DivW-2:0], 1'b0};
        ge     = rr >= dd;
        rem_nx = ge ? rr - dd : rr;
        ek     = r_e[r_k];
        emag   = ek[rptu_pkg::SumW-1] ? -ek : ek;
        qr     = r_quo + rptu_pkg::QuoW'({r_rem[rptu_pkg::DivW-2:0], 1'b0} >= dd);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rptu_pkg::MS_IDLE:  if (i_start) n_state = rptu_pkg::MS_PROD;
            rptu_pkg::MS_PROD:  n_state = rptu_pkg::MS_SUM;
            rptu_pkg::MS_SUM:   n_state = rptu_pkg::MS_LOAD;
            rptu_pkg::MS_LOAD:  n_state = (r_n == '0) ? rptu_pkg::MS_IDLE : rptu_pkg::MS_DIV;
            rptu_pkg::MS_DIV:   if (r_cnt == rptu_pkg::CntW'(rptu_pkg::FracM))
                                    n_state = rptu_pkg::MS_ROUND;
            rptu_pkg::MS_ROUND: n_state = (r_k == rptu_pkg::KW'(8)) ? rptu_pkg::MS_IDLE
                                                                   : rptu_pkg::MS_LOAD;
            default:            n_state = rptu_pkg::MS_IDLE;
        endcase
        // a further rotation write restarts the build from the new quaternion
        if (i_start) n_state = rptu_pkg::MS_PROD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rptu_pkg::MS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_m[i] <= (i % 4 == 0) ? rptu_pkg::MatW'(1 << rptu_pkg::FracM) : '0;
            end
            r_bad <= 1'b0;
            r_k   <= '0;
            r_cnt <= '0;
        end else begin
            case (r_state)
                rptu_pkg::MS_PROD: begin
                    r_pp[0] <= i_quat.w * i_quat.w;
                    r_pp[1] <= i_quat.x * i_quat.x;
                    r_pp[2] <= i_quat.y * i_quat.y;
                    r_pp[3] <= i_quat.z * i_quat.z;
                    r_pp[4] <= i_quat.x * i_quat.y;
                    r_pp[5] <= i_quat.w * i_quat.z;
                    r_pp[6] <= i_quat.x * i_quat.z;
                    r_pp[7] <= i_quat.w * i_quat.y;
                    r_pp[8] <= i_quat.y * i_quat.z;
                    r_pp[9] <= i_quat.w * i_quat.x;
                    r_k     <= '0;
                end
                rptu_pkg::MS_SUM: begin
                    r_n    <= sx(r_pp[0]) + sx(r_pp[1]) + sx(r_pp[2]) + sx(r_pp[3]);
                    r_e[0] <= sx(r_pp[0]) + sx(r_pp[1]) - sx(r_pp[2]) - sx(r_pp[3]);
                    r_e[1] <= (sx(r_pp[4]) - sx(r_pp[5])) <<< 1;
                    r_e[2] <= (sx(r_pp[6]) + sx(r_pp[7])) <<< 1;
                    r_e[3] <= (sx(r_pp[4]) + sx(r_pp[5])) <<< 1;
                    r_e[4] <= sx(r_pp[0]) - sx(r_pp[1]) + sx(r_pp[2]) - sx(r_pp[3]);
                    r_e[5] <= (sx(r_pp[8]) - sx(r_pp[9])) <<< 1;
                    r_e[6] <= (sx(r_pp[6]) - sx(r_pp[7])) <<< 1;
                    r_e[7] <= (sx(r_pp[8]) + sx(r_pp[9])) <<< 1;
                    r_e[8] <= sx(r_pp[0]) - sx(r_pp[1]) - sx(r_pp[2]) + sx(r_pp[3]);
                end
                rptu_pkg::MS_LOAD: begin
                    r_bad <= (r_n == '0);
                    r_rem <= rptu_pkg::DivW'(emag);
                    r_quo <= '0;
                    r_cnt <= '0;
                end
                rptu_pkg::MS_DIV: begin
                    r_rem <= rem_nx;
                    r_quo <= {r_quo[rptu_pkg::QuoW-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                end
                rptu_pkg::MS_ROUND: begin
                    r_m[r_k] <= ek[rptu_pkg::SumW-1] ? -rptu_pkg::MatW'(qr)
                                                      : rptu_pkg::MatW'(qr);
                    r_k      <= r_k + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_m         = r_m;
    assign o_stat.busy = (r_state != rptu_pkg::MS_IDLE);
    assign o_stat.bad  = r_bad;

endmodule

FILE: verif/rigid_point_transform_unit_tb.sv
// Self-checking testbench for the rigid point transform unit
module rigid_point_transform_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rptu_pkg::IdxW-1:0] UNUSED_IDX = 3'd7;
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_POINTS = 210;

    class point_scoreboard;
        logic signed [rptu_pkg::QuatW-1:0]  quat [4];
        logic signed [rptu_pkg::CoordW-1:0] shift [3];
        rptu_pkg::t_out_beat expected_beats [$];
        int errors, points, results, sat_seen, bad_seen;

        function new();
            quat = '{default: '0};
            quat[3] = 18'sd65536;
            shift = '{default: '0};
        endfunction

        function void set_reg(logic [rptu_pkg::IdxW-1:0] idx, logic [rptu_pkg::CfgW-1:0] val);
            if (idx < 4)
                quat[idx] = val[rptu_pkg::QuatW-1:0];
            else if (idx < 7)
                shift[idx - 4] = val[rptu_pkg::CoordW-1:0];
        endfunction

        function rptu_pkg::t_out_beat transform(rptu_pkg::t_in_beat b);
            logic signed [127:0] x, y, z, w, n, mag, q, acc, r;
            logic signed [127:0] ent [9];
            logic signed [127:0] pt [3];
            rptu_pkg::t_out_beat o;
            logic signed [rptu_pkg::CoordW-1:0] res [3];
            x = quat[0]; y = quat[1]; z = quat[2]; w = quat[3];
            pt[0] = $signed(b.pt_x); pt[1] = $signed(b.pt_y); pt[2] = $signed(b.pt_z);
            n = w*w + x*x + y*y + z*z;
            o = '0;
            if (n == 0) begin
                o.out_x = shift[0]; o.out_y = shift[1]; o.out_z = shift[2];
                o.bad_rotation = 1'b1;
                return o;
            end
            ent[0] = w*w + x*x - y*y - z*z;
            ent[1] = 2 * (x*y - w*z);
            ent[2] = 2 * (x*z + w*y);
            ent[3] = 2 * (x*y + w*z);
            ent[4] = w*w - x*x + y*y - z*z;
            ent[5] = 2 * (y*z - w*x);
            ent[6] = 2 * (x*z - w*y);
            ent[7] = 2 * (y*z + w*x);
            ent[8] = w*w - x*x - y*y + z*z;
            for (int k = 0; k < 9; k++) begin
                mag = (ent[k] < 0) ? -ent[k] : ent[k];
                q = ((mag <<< (rptu_pkg::FracM + 1)) + n) / (2 * n);
                ent[k] = (ent[k] < 0) ? -q : q;
            end
            for (int i = 0; i < 3; i++) begin
                acc = shift[i];
                acc = acc <<< rptu_pkg::FracM;
                for (int j = 0; j < 3; j++)
                    acc = acc + ent[i*3 + j] * pt[j];
                acc = acc + (128'sd1 <<< (rptu_pkg::FracM - 1));
                r = acc >>> rptu_pkg::FracM;
                if (r > 128'sd2147483647) begin
                    res[i] = 32'sh7fffffff; o.saturated = 1'b1;
                end else if (r < -128'sd2147483648) begin
                    res[i] = 32'sh80000000; o.saturated = 1'b1;
                end else begin
                    res[i] = r[rptu_pkg::CoordW-1:0];
                end
            end
            o.out_x = res[0]; o.out_y = res[1]; o.out_z = res[2];
            return o;
        endfunction

        function void note_point(rptu_pkg::t_in_beat b);
            expected_beats.push_back(transform(b));
            points++;
        endfunction

        task report(string what, logic [rptu_pkg::CoordW-1:0] got,
                    logic [rptu_pkg::CoordW-1:0] want);
            $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
            errors++;
        endtask

        task check_result(rptu_pkg::t_out_beat got);
            rptu_pkg::t_out_beat want;
            if (expected_beats.size() == 0) begin
                report("unexpected beat", got.out_x, '0);
                return;
            end
            want = expected_beats.pop_front();
            results++;
            sat_seen += got.saturated;
            bad_seen += got.bad_rotation;
            if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
            if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
            if (got.out_z !== want.out_z) report("out_z", got.out_z, want.out_z);
            if (got.saturated !== want.saturated)
                report("saturated", got.saturated, want.saturated);
            if (got.bad_rotation !== want.bad_rotation)
                report("bad_rotation", got.bad_rotation, want.bad_rotation);
        endtask
    endclass

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall, o_out_valid, i_out_stall;
    rptu_pkg::t_in_beat i_in_data;
    rptu_pkg::t_out_beat o_out_data;
    logic i_cfg_we;
    logic [rptu_pkg::IdxW-1:0] i_cfg_idx;
    logic [rptu_pkg::CfgW-1:0] i_cfg_data;

    point_scoreboard sb;
    bit calm;
    int idle_cycles;
    int stall_left;

    rigid_point_transform_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // beat accounting and result checking, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_point(i_in_data);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            if (calm || $urandom_range(0, 99) < 60) begin
                i_out_stall <= 1'b0;
                stall_left <= $urandom_range(0, 6);
            end else begin
                i_out_stall <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    task automatic send_point(rptu_pkg::t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_beats.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rptu_pkg::IdxW-1:0] idx, logic [rptu_pkg::CfgW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_pose(logic [rptu_pkg::CfgW-1:0] qx, logic [rptu_pkg::CfgW-1:0] qy,
                            logic [rptu_pkg::CfgW-1:0] qz, logic [rptu_pkg::CfgW-1:0] qw,
                            logic [rptu_pkg::CfgW-1:0] tx, logic [rptu_pkg::CfgW-1:0] ty,
                            logic [rptu_pkg::CfgW-1:0] tz);
        write_reg(rptu_pkg::REG_ROT_X, qx);
        write_reg(rptu_pkg::REG_ROT_Y, qy);
        write_reg(rptu_pkg::REG_ROT_Z, qz);
        write_reg(rptu_pkg::REG_ROT_W, qw);
        write_reg(rptu_pkg::REG_SHIFT_X, tx);
        write_reg(rptu_pkg::REG_SHIFT_Y, ty);
        write_reg(rptu_pkg::REG_SHIFT_Z, tz);
    endtask

    function automatic logic [rptu_pkg::CoordW-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom();
        if (r < 8) return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
        if (r == 8) return 32'h7fffffff;
        return 32'h80000000;
    endfunction

    function automatic logic [rptu_pkg::CfgW-1:0] rand_quat();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom();
        if (r == 7) return 32'h0001ffff;
        if (r == 8) return 32'h00020000;
        return 32'h0;
    endfunction

    task automatic send_xyz(logic [rptu_pkg::CoordW-1:0] a, logic [rptu_pkg::CoordW-1:0] b,
                            logic [rptu_pkg::CoordW-1:0] c);
        rptu_pkg::t_in_beat p;
        p.pt_x = a; p.pt_y = b; p.pt_z = c;
        send_point(p);
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        idle_cycles = 0;
        stall_left = 0;
        calm = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity pose from reset
        send_xyz(32'h0, 32'h0, 32'h0);
        send_xyz(32'h7fffffff, 32'h80000000, 32'h00010000);
        send_xyz(32'h80000000, 32'h7fffffff, 32'hffffffff);
        send_xyz(32'hffffffff, 32'h00000001, 32'h7fffffff);
        drain();
        // zero quaternion returns the shift; unknown index write is dropped
        set_pose(0, 0, 0, 0, 32'h12345678, 32'h80000000, 32'h7fffffff);
        write_reg(UNUSED_IDX, 32'hffffffff);
        send_xyz(32'h7fffffff, 32'h80000000, 32'h0);
        send_xyz(32'h00010000, 32'h00020000, 32'h00030000);
        drain();
        // largest quaternions with extreme shifts drive the clip path
        set_pose(32'h20000, 32'h20000, 32'h20000, 32'h20000,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_xyz(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_xyz(32'h80000000, 32'h80000000, 32'h80000000);
        send_xyz(32'h0, 32'h0, 32'h0);
        drain();
        set_pose(32'h1ffff, 32'h1ffff, 32'h1ffff, 32'h1ffff,
                 32'h80000000, 32'h7fffffff, 32'h0);
        send_xyz(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_xyz(32'h80000000, 32'h7fffffff, 32'h0);
        drain();
        // quarter turn about z, non-unit length, and a lone x component
        set_pose(0, 0, 32'h10000, 32'h10000, 32'h00010000, 0, 0);
        send_xyz(32'h00010000, 32'h0, 32'h0);
        send_xyz(32'h0, 32'h00010000, 32'hfff00000);
        drain();
        set_pose(32'h3ffff, 0, 0, 0, 0, 32'hffff0000, 0);
        send_xyz(32'h00010000, 32'h00010000, 32'h00010000);
        send_xyz(32'h00000001, 32'hffffffff, 32'h7fffffff);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            calm = (ph % 3 == 1);
            set_pose(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                     ($urandom_range(0, 3) == 0) ? $urandom() : rand_coord(),
                     rand_coord(), rand_coord());
            for (int k = 0; k < PHASE_POINTS; k++)
                send_xyz(rand_coord(), rand_coord(), rand_coord());
            drain();
        end
        calm = 1'b0;

        repeat (20) @(posedge i_clk);
        if (sb.expected_beats.size() != 0)
            sb.report("results missing", sb.expected_beats.size(), 0);
        $display("covered %0d points, %0d results checked over 15 poses", sb.points,
                 sb.results);
        $display("saturated results %0d, bad rotation results %0d", sb.sat_seen,
                 sb.bad_seen);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: rigid_point_transform_unit.f
+incdir+src
src/rptu_pkg.sv
src/rptu_matrix.sv
src/rigid_point_transform_unit.sv
verif/rigid_point_transform_unit_tb.sv
